@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL of the sorted record table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/srt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg
// Types, codes and the name truncation helper of the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int NAME_BYTES = 19;
    localparam int NAME_W     = 8 * NAME_BYTES;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_POS   = 3'd4
    } t_status;

    // outcome of comparing a stored record against the key
    typedef struct packed {
        logic name_eq;
        logic greater;
    } t_cmp_res;

    // Zero every byte after the first zero byte. Two truncated names compare
    // as big-endian unsigned words exactly as strcmp orders the originals.
    function automatic logic [NAME_W-1:0] trunc_name(input logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] res;
        logic              live;
        res  = '0;
        live = 1'b1;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (live) begin
                res[NAME_W-1-8*k -: 8] = name[NAME_W-1-8*k -: 8];
            end
            if (name[NAME_W-1-8*k -: 8] == 8'h00) begin
                live = 1'b0;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ src/srt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_ram
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
    parameter int  DEPTH = 32,
    parameter int  WIDTH = 168,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-first; callers never use data read from an entry written in that cycle
    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule
`default_nettype wire

@@ src/srt_key_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_key_cmp
// Orders a stored record against the key: name first, then volume.
// ----------------------------------------------------------------------------
module srt_key_cmp
    import srt_pkg::*;
#(
    parameter int VOL_W = 16
) (
    input  wire logic [NAME_W-1:0] i_rec_name,
    input  wire logic [VOL_W-1:0]  i_rec_vol,
    input  wire logic [NAME_W-1:0] i_key_tr,    // key, already truncated
    input  wire logic [VOL_W-1:0]  i_key_vol,
    output t_cmp_res               o_res
);

    logic [NAME_W-1:0] rec_tr;

    assign rec_tr        = trunc_name(i_rec_name);
    assign o_res.name_eq = (rec_tr == i_key_tr);
    assign o_res.greater = (rec_tr > i_key_tr) ||
                           ((rec_tr == i_key_tr) && (i_rec_vol > i_key_vol));

endmodule
`default_nettype wire

@@ src/sorted_record_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Clear, an insert into an empty table, and an insert, remove or read refused by its status
// set the result straight from idle. Insert otherwise walks down from the top, moving each
// greater record up, then writes the key. Remove scans every record from position 0; read
// returns its entry from S_RD. One item at a time: the record memory has one read and one
// write port, so the sequencer makes one compare and one move per cycle. Reset clears
// the count and control; memory is not cleared, entries at or above the count are never read.
// ----------------------------------------------------------------------------
// sorted_record_table
// Bounded table of name/volume records kept in ascending order in one RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_record_table
    import srt_pkg::*;
#(
    parameter int CAPACITY    = 32,
    parameter int VOLUME_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item in
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_name_part0,
    input  wire logic [63:0] i_name_part1,
    input  wire logic [23:0] i_name_part2,
    input  wire logic [15:0] i_volume,
    input  wire logic [4:0]  i_position,
    // result out
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [63:0]      o_out_name_part0,
    output logic [63:0]      o_out_name_part1,
    output logic [23:0]      o_out_name_part2,
    output logic [15:0]      o_out_volume,
    output logic [5:0]       o_entry_total,
    output logic             o_is_empty,
    output logic             o_is_full
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = CNT_W + 5;           // common width for pos vs count
    localparam int REC_W = NAME_W + VOLUME_BITS;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_INS      = 5'b00010,   // walking down, moving greater records up
        S_INS_LAST = 5'b00100,   // every record moved; key goes to position 0
        S_REM      = 5'b01000,   // scanning up, closing the gap behind a hit
        S_RD       = 5'b10000    // read data arriving
    } t_state;

    // ------------------------------------------------------------------
    // Control and key registers
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_didx, n_didx;          // entry whose data is on mem_q
    logic              r_found, n_found;

    logic [NAME_W-1:0]      r_key_name;         // as given, for storing
    logic [NAME_W-1:0]      r_key_tr;           // truncated, for comparing
    logic [VOLUME_BITS-1:0] r_key_vol;

    // output register
    logic              r_ov;
    t_status           r_o_status;
    logic [NAME_W-1:0] r_o_name;
    logic [15:0]       r_o_vol;
    logic [CNT_W-1:0]  r_o_cnt;
    logic              r_o_empty;
    logic              r_o_full;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_take;

    assign out_take = r_ov && !i_stall;
    // a new item only once the sequencer is idle and the result slot frees up
    assign o_stall  = !((r_state == S_IDLE) && (!r_ov || !i_stall));
    assign in_acc   = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Record memory and comparator
    // ------------------------------------------------------------------
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [REC_W-1:0] mem_q;
    t_cmp_res         cmp;

    srt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (REC_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q)
    );

    srt_key_cmp #(
        .VOL_W (VOLUME_BITS)
    ) u_cmp (
        .i_rec_name (mem_q[REC_W-1 -: NAME_W]),
        .i_rec_vol  (mem_q[VOLUME_BITS-1:0]),
        .i_key_tr   (r_key_tr),
        .i_key_vol  (r_key_vol),
        .o_res      (cmp)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // Insert: the records greater than the key form a suffix of the table,
    // so walk down from the top, moving each greater record up one place,
    // and drop the key in behind the first record that is not greater.
    // Remove: scan up from position 0; after the first name match every
    // later record is written one place down.
    // Each read whose data is used meets no write or one two places away,
    // so used data never comes from a fresh write; no forwarding is needed.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] last_idx;
    logic             tbl_full;
    logic             tbl_empty;
    logic             pos_bad;
    logic             found_now;

    logic             res_set;
    t_status          res_status;
    logic             res_rd;

    assign last_idx  = IDX_W'(r_cnt - CNT_W'(1));
    assign tbl_full  = (r_cnt == CNT_W'(CAPACITY));
    assign tbl_empty = (r_cnt == '0);
    assign pos_bad   = (POS_W'(i_position) >= POS_W'(r_cnt));
    assign found_now = r_found || cmp.name_eq;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_didx     = r_didx;
        n_found    = r_found;
        rd_addr    = r_didx;
        wr_en      = 1'b0;
        wr_addr    = r_didx;
        wr_data    = mem_q;
        res_set    = 1'b0;
        res_status = ST_OK;
        res_rd     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_INSERT: begin
                            if (tbl_full) begin
                                res_set    = 1'b1;
                                res_status = ST_FULL;
                            end else if (tbl_empty) begin
                                // first record: straight into position 0
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = {i_name_part0, i_name_part1, i_name_part2,
                                           VOLUME_BITS'(i_volume)};
                                n_cnt   = r_cnt + CNT_W'(1);
                                res_set = 1'b1;
                            end else begin
                                rd_addr = last_idx;
                                n_didx  = last_idx;
                                n_state = S_INS;
                            end
                        end
                        OP_REMOVE: begin
                            if (tbl_empty) begin
                                res_set    = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                rd_addr = '0;
                                n_didx  = '0;
                                n_found = 1'b0;
                                n_state = S_REM;
                            end
                        end
                        OP_READ: begin
                            if (tbl_empty) begin
                                res_set    = 1'b1;
                                res_status = ST_EMPTY;
                            end else if (pos_bad) begin
                                res_set    = 1'b1;
                                res_status = ST_BAD_POS;
                            end else begin
                                rd_addr = IDX_W'(i_position);
                                n_state = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            res_set = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_didx + IDX_W'(1);
                if (cmp.greater) begin
                    // move it up and keep walking
                    wr_data = mem_q;
                    if (r_didx == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        rd_addr = r_didx - IDX_W'(1);
                        n_didx  = r_didx - IDX_W'(1);
                    end
                end else begin
                    wr_data = {r_key_name, r_key_vol};
                    n_cnt   = r_cnt + CNT_W'(1);
                    res_set = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_INS_LAST: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {r_key_name, r_key_vol};
                n_cnt   = r_cnt + CNT_W'(1);
                res_set = 1'b1;
                n_state = S_IDLE;
            end

            S_REM: begin
                if (r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_didx - IDX_W'(1);
                    wr_data = mem_q;
                end
                n_found = found_now;
                if (r_didx == last_idx) begin
                    res_set = 1'b1;
                    n_state = S_IDLE;
                    if (found_now) begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end else begin
                        res_status = ST_NOT_FOUND;
                    end
                end else begin
                    rd_addr = r_didx + IDX_W'(1);
                    n_didx  = r_didx + IDX_W'(1);
                end
            end

            S_RD: begin
                res_set = 1'b1;
                res_rd  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_didx  <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_didx  <= n_didx;
            r_found <= n_found;
        end
    end

    // key taken with the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key_name <= {i_name_part0, i_name_part1, i_name_part2};
            r_key_tr   <= trunc_name({i_name_part0, i_name_part1, i_name_part2});
            r_key_vol  <= VOLUME_BITS'(i_volume);
        end
    end

    // result slot: set wins over a take in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_set) begin
            r_ov <= 1'b1;
        end else if (out_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_set) begin
            r_o_status <= res_status;
            r_o_name   <= res_rd ? mem_q[REC_W-1 -: NAME_W] : '0;
            r_o_vol    <= res_rd ? 16'(mem_q[VOLUME_BITS-1:0]) : '0;
            r_o_cnt    <= n_cnt;
            r_o_empty  <= (n_cnt == '0);
            r_o_full   <= (n_cnt == CNT_W'(CAPACITY));
        end
    end

    assign o_valid          = r_ov;
    assign o_status         = r_o_status;
    assign o_out_name_part0 = r_o_name[NAME_W-1 -: 64];
    assign o_out_name_part1 = r_o_name[NAME_W-65 -: 64];
    assign o_out_name_part2 = r_o_name[23:0];
    assign o_out_volume     = r_o_vol;
    assign o_entry_total    = 6'(r_o_cnt);
    assign o_is_empty       = r_o_empty;
    assign o_is_full        = r_o_full;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_result_slot_free, i_clk, i_rst_n, res_set, !r_ov || out_take)
    `ASSERT_IMPL(a_write_in_table, i_clk, i_rst_n, wr_en, CNT_W'(wr_addr) <= r_cnt)
    `ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, in_acc && (i_operation == OP_CLEAR), r_cnt == '0)

endmodule
`default_nettype wire
